// ===== hdl/rtsf_pkg.sv =====
// rtsf_pkg: shared types, constants and register codes of the touch sample filter.
// No dependencies; every other file of the block imports it.
package rtsf_pkg;

	// burst shape
	localparam int BURST_LEN   = 5;
	localparam int TRIM_COUNT  = 1;
	localparam int SAMPLE_BITS = 12;

	localparam int CNT_W    = $clog2(BURST_LEN);
	localparam int KEEP_N   = (BURST_LEN > 2 * TRIM_COUNT) ? BURST_LEN - 2 * TRIM_COUNT : 1;
	localparam int KEEP_LO  = (BURST_LEN > 2 * TRIM_COUNT) ? TRIM_COUNT : BURST_LEN / 2;
	localparam int SUM_W    = SAMPLE_BITS + $clog2(KEEP_N);
	localparam int RECIP_K  = SUM_W + 4;
	localparam int RECIP_W  = RECIP_K + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_K) + KEEP_N - 1) / KEEP_N);
	localparam logic [CNT_W-1:0]   LAST_POS = CNT_W'(BURST_LEN - 1);

	// calibration arithmetic
	localparam int POS_W  = 16;
	localparam int GAIN_W = 18;
	localparam int OFS_W  = 16;
	localparam int WIN_W  = 12;
	localparam int PROD_W = GAIN_W + SAMPLE_BITS + 1;
	localparam int T_W    = ((PROD_W > OFS_W + POS_W) ? PROD_W : OFS_W + POS_W) + 1;

	typedef logic [SAMPLE_BITS-1:0]  sample_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic signed [OFS_W-1:0]  ofs_t;
	typedef logic [WIN_W-1:0]        win_t;

	// neighbor handoff between sort cells
	typedef struct packed {
		logic    valid;
		logic    keep;
		sample_t val;
	} rtsf_link_t;

	// scan order
	typedef enum logic [1:0] {
		BURST_X1 = 2'd0,
		BURST_Y1 = 2'd1,
		BURST_X2 = 2'd2,
		BURST_Y2 = 2'd3
	} burst_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_PAIR,
		ST_MUL,
		ST_CAL,
		ST_EMIT
	} state_t;

	// configuration map, one 32-bit word per register
	localparam int CFG_NUM = 6;
	localparam int ADDR_W  = $clog2(CFG_NUM * 4);
	localparam int REGI_W  = ADDR_W - 2;
	localparam logic [REGI_W-1:0] REG_RAW_MODE     = REGI_W'(0);
	localparam logic [REGI_W-1:0] REG_X_GAIN       = REGI_W'(1);
	localparam logic [REGI_W-1:0] REG_Y_GAIN       = REGI_W'(2);
	localparam logic [REGI_W-1:0] REG_X_OFFSET     = REGI_W'(3);
	localparam logic [REGI_W-1:0] REG_Y_OFFSET     = REGI_W'(4);
	localparam logic [REGI_W-1:0] REG_MATCH_WINDOW = REGI_W'(5);

	localparam gain_t X_GAIN_RST = -18'sd5839;
	localparam gain_t Y_GAIN_RST = -18'sd4463;
	localparam ofs_t  X_OFS_RST  = 16'sd340;
	localparam ofs_t  Y_OFS_RST  = 16'sd260;
	localparam win_t  WIN_RST    = 12'd50;

	localparam pos_t POS_IDLE = 16'hffff;

endpackage

// ===== hdl/rtsf_req_if.sv =====
// rtsf_req_if: request channel into the filter (scan tick or converter sample).
// Depends on rtsf_pkg.
interface rtsf_req_if import rtsf_pkg::*;;
	logic    valid;
	logic    ready;
	logic    req_type;
	sample_t sample;

	modport source(output valid, req_type, sample, input ready);
	modport sink(input valid, req_type, sample, output ready);
endinterface

// ===== hdl/rtsf_res_if.sv =====
// rtsf_res_if: result channel out of the filter (press state and positions).
// Depends on rtsf_pkg.
interface rtsf_res_if import rtsf_pkg::*;;
	logic valid;
	logic ready;
	logic touching;
	pos_t pos_x;
	pos_t pos_y;
	pos_t first_x;
	pos_t first_y;
	logic press_latched;
	logic pair_ok;

	modport source(output valid, touching, pos_x, pos_y, first_x, first_y, press_latched,
		pair_ok, input ready);
	modport sink(input valid, touching, pos_x, pos_y, first_x, first_y, press_latched,
		pair_ok, output ready);
endinterface

// ===== hdl/rtsf_sort_cell.sv =====
// rtsf_sort_cell: one slot of the insertion sort row.
// Depends on rtsf_pkg.
module rtsf_sort_cell import rtsf_pkg::*; (
	input  logic       clk,
	input  logic       ins,
	input  logic       occupied,
	input  sample_t    din,
	input  rtsf_link_t left,
	output rtsf_link_t right,
	output sample_t    val
);
	sample_t val_q;
	logic    keep;

	// an occupied slot holding a value not above the new one stays put
	assign keep  = occupied && (val_q <= din);
	assign right = '{valid: occupied, keep: keep, val: val_q};
	assign val   = val_q;

	always_ff @(posedge clk) begin
		if (ins && !keep) begin
			if (left.valid && !left.keep) begin
				val_q <= left.val;
			end else begin
				val_q <= din;
			end
		end
	end
endmodule

// ===== hdl/rtsf_sort_chain.sv =====
// rtsf_sort_chain: row of sort cells that keeps a burst ordered, plus the trimmed sum.
// Depends on rtsf_pkg and rtsf_sort_cell.
module rtsf_sort_chain import rtsf_pkg::*; (
	input  logic             clk,
	input  logic             ins,
	input  logic [CNT_W-1:0] count,
	input  sample_t          din,
	output logic [SUM_W-1:0] trim_sum
);
	rtsf_link_t link [BURST_LEN];
	sample_t    vals [BURST_LEN];

	for (genvar i = 0; i < BURST_LEN; i++) begin : g_cell
		rtsf_link_t left;
		logic       occupied;

		assign occupied = CNT_W'(i) < count;
		if (i == 0) begin : g_head
			assign left = '0;
		end else begin : g_body
			assign left = link[i-1];
		end

		rtsf_sort_cell u_cell (
			.clk     (clk),
			.ins     (ins),
			.occupied(occupied),
			.din     (din),
			.left    (left),
			.right   (link[i]),
			.val     (vals[i])
		);
	end

	// middle slots only; min and max ends are dropped
	always_comb begin
		trim_sum = '0;
		for (int k = 0; k < KEEP_N; k++) begin
			trim_sum = trim_sum + SUM_W'(vals[KEEP_LO + k]);
		end
	end
endmodule

// ===== hdl/rtsf_calib.sv =====
// rtsf_calib: gain * value / 65536 + offset, truncated toward zero, clamped to 0..65535.
// Depends on rtsf_pkg.
module rtsf_calib import rtsf_pkg::*; (
	input  logic    clk,
	input  logic    load,
	input  sample_t v,
	input  gain_t   gain,
	input  ofs_t    offset,
	output pos_t    cal
);
	localparam logic signed [T_W-1:0] LOW_MASK = T_W'((1 << POS_W) - 1);
	localparam logic signed [T_W-1:0] POS_MAX  = T_W'((1 << POS_W) - 1);

	logic signed [PROD_W-1:0] prod_s1;
	ofs_t                     ofs_s1;
	logic signed [T_W-1:0]    t;
	logic signed [T_W-1:0]    biased;
	logic signed [T_W-1:0]    q;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= gain * $signed({1'b0, v});
			ofs_s1  <= offset;
		end
	end

	always_comb begin
		t      = T_W'(prod_s1) + (T_W'(ofs_s1) <<< POS_W);
		// negative values round up before the shift so the result truncates toward zero
		biased = t + (t[T_W-1] ? LOW_MASK : '0);
		q      = biased >>> POS_W;
		if (q[T_W-1]) begin
			cal = '0;
		end else if (q > POS_MAX) begin
			cal = '1;
		end else begin
			cal = q[POS_W-1:0];
		end
	end
endmodule

// ===== hdl/resistive_touch_sample_filter_unit.sv =====
// resistive_touch_sample_filter_unit: top level of the touch sample filter.
// Depends on rtsf_pkg, rtsf_req_if, rtsf_res_if, rtsf_sort_chain, rtsf_calib.
//
// Usage:
//  - req (sink): one request per converter sample (req_type 1) or per pen-up tick
//    (req_type 0). A pen-down scan is 5 X, 5 Y, 5 X, 5 Y samples in that order.
//  - res (source): one result per pen-up tick and one per completed scan; other
//    samples give none. Results are held in an output register until taken.
//  - APB port: six 32-bit registers at 0x00..0x14 (raw_mode, x_gain, y_gain,
//    x_offset, y_offset, match_window). Write only while the block is idle.
// Sequencing:
//  - a sample that does not close a burst goes into the sort row; the state machine stays idle.
//  - closing one of the first three bursts runs the trimmed sum, then the
//    multiply by the reciprocal of the kept count.
//  - closing the scan reaches the result register in steps: sum, mean, pair check,
//    calibration multiply, offset and clamp, output load.
//  - a pen-up tick goes straight to the output load.
//  The state machine handles one request at a time; req.ready is low while it works.
// Reset clears the scan position, positions, press flags and loads register defaults.
// If the receiver stalls, the next request is still accepted; the block only waits
// when a new result is ready and the output register is still full.
module resistive_touch_sample_filter_unit import rtsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	rtsf_req_if.sink          req,
	rtsf_res_if.source        res
);

	// ---------------- configuration registers ----------------
	logic  raw_mode_q;
	gain_t x_gain_q, y_gain_q;
	ofs_t  x_offset_q, y_offset_q;
	win_t  match_window_q;
	logic  cfg_wr;
	logic [REGI_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q     <= 1'b0;
			x_gain_q       <= X_GAIN_RST;
			y_gain_q       <= Y_GAIN_RST;
			x_offset_q     <= X_OFS_RST;
			y_offset_q     <= Y_OFS_RST;
			match_window_q <= WIN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RAW_MODE:     raw_mode_q     <= pwdata[0];
				REG_X_GAIN:       x_gain_q       <= pwdata[GAIN_W-1:0];
				REG_Y_GAIN:       y_gain_q       <= pwdata[GAIN_W-1:0];
				REG_X_OFFSET:     x_offset_q     <= pwdata[OFS_W-1:0];
				REG_Y_OFFSET:     y_offset_q     <= pwdata[OFS_W-1:0];
				REG_MATCH_WINDOW: match_window_q <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RAW_MODE:     prdata = 32'(raw_mode_q);
			REG_X_GAIN:       prdata = 32'(x_gain_q);
			REG_Y_GAIN:       prdata = 32'(y_gain_q);
			REG_X_OFFSET:     prdata = 32'(x_offset_q);
			REG_Y_OFFSET:     prdata = 32'(y_offset_q);
			REG_MATCH_WINDOW: prdata = 32'(match_window_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	state_t state_q, state_d;
	logic   req_acc;
	logic   out_free;
	logic   emit_load;
	logic   sum_load, div_load, pair_load, mul_load, cal_load;

	assign req_acc  = req.valid && req.ready;
	assign out_free = !res.valid || res.ready;

	logic [CNT_W-1:0] pos_q;
	burst_t           burst_q, done_burst_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (!req.req_type) begin
						state_d = ST_EMIT;
					end else if (pos_q == LAST_POS) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  state_d = (done_burst_q == BURST_Y2) ? ST_PAIR : ST_IDLE;
			ST_PAIR: state_d = ST_MUL;
			ST_MUL:  state_d = ST_CAL;
			ST_CAL:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		sum_load  = 1'b0;
		div_load  = 1'b0;
		pair_load = 1'b0;
		mul_load  = 1'b0;
		cal_load  = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SUM:  sum_load  = 1'b1;
			ST_DIV:  div_load  = 1'b1;
			ST_PAIR: pair_load = 1'b1;
			ST_MUL:  mul_load  = 1'b1;
			ST_CAL:  cal_load  = 1'b1;
			ST_EMIT: emit_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- scan position ----------------
	logic ins;
	assign ins = req_acc && req.req_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			burst_q      <= BURST_X1;
			done_burst_q <= BURST_X1;
		end else if (req_acc) begin
			if (!req.req_type) begin
				// pen-up drops any partial scan
				pos_q   <= '0;
				burst_q <= BURST_X1;
			end else if (pos_q == LAST_POS) begin
				pos_q        <= '0;
				burst_q      <= burst_t'(burst_q + 2'd1);
				done_burst_q <= burst_q;
			end else begin
				pos_q <= pos_q + CNT_W'(1);
			end
		end
	end

	// ---------------- sort row and burst mean ----------------
	logic [SUM_W-1:0]         trim_sum;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W+RECIP_W-1:0] mean_prod;
	sample_t                  mean;

	rtsf_sort_chain u_chain (
		.clk     (clk),
		.ins     (ins),
		.count   (pos_q),
		.din     (req.sample),
		.trim_sum(trim_sum)
	);

	// divide by the kept count through its reciprocal
	assign mean_prod = (SUM_W+RECIP_W)'(sum_q) * (SUM_W+RECIP_W)'(RECIP);
	assign mean      = SAMPLE_BITS'(mean_prod >> RECIP_K);

	sample_t x1_q, y1_q, x2_q, y2_q;

	always_ff @(posedge clk) begin
		if (sum_load) begin
			sum_q <= trim_sum;
		end
		if (div_load) begin
			case (done_burst_q)
				BURST_X1: x1_q <= mean;
				BURST_Y1: y1_q <= mean;
				BURST_X2: x2_q <= mean;
				BURST_Y2: y2_q <= mean;
				default: ;
			endcase
		end
	end

	// ---------------- pair check ----------------
	localparam int DW = (SAMPLE_BITS > WIN_W) ? SAMPLE_BITS : WIN_W;

	logic [DW-1:0]        dx, dy;
	logic                 ok;
	logic [SAMPLE_BITS:0] sx, sy;
	logic                 ok_q;
	sample_t              ax_q, ay_q;

	always_comb begin
		dx = (x1_q > x2_q) ? DW'(x1_q - x2_q) : DW'(x2_q - x1_q);
		dy = (y1_q > y2_q) ? DW'(y1_q - y2_q) : DW'(y2_q - y1_q);
		ok = (dx < DW'(match_window_q)) && (dy < DW'(match_window_q));
		sx = (SAMPLE_BITS+1)'(x1_q) + (SAMPLE_BITS+1)'(x2_q);
		sy = (SAMPLE_BITS+1)'(y1_q) + (SAMPLE_BITS+1)'(y2_q);
	end

	always_ff @(posedge clk) begin
		if (pair_load) begin
			ok_q <= ok;
			ax_q <= sx[SAMPLE_BITS:1];
			ay_q <= sy[SAMPLE_BITS:1];
		end
	end

	// ---------------- calibration ----------------
	pos_t cal_x, cal_y;

	rtsf_calib u_cal_x (
		.clk   (clk),
		.load  (mul_load),
		.v     (ax_q),
		.gain  (x_gain_q),
		.offset(x_offset_q),
		.cal   (cal_x)
	);

	rtsf_calib u_cal_y (
		.clk   (clk),
		.load  (mul_load),
		.v     (ay_q),
		.gain  (y_gain_q),
		.offset(y_offset_q),
		.cal   (cal_y)
	);

	// ---------------- press tracking ----------------
	pos_t cur_x_q, cur_y_q, start_x_q, start_y_q;
	pos_t nx, ny;
	logic down_q, latched_q;

	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		if (ok_q) begin
			nx = raw_mode_q ? POS_W'(ax_q) : cal_x;
			ny = raw_mode_q ? POS_W'(ay_q) : cal_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			down_q    <= 1'b0;
			latched_q <= 1'b0;
		end else if (req_acc && !req.req_type) begin
			if (down_q) begin
				down_q <= 1'b0;
			end else begin
				start_x_q <= '0;
				start_y_q <= '0;
				cur_x_q   <= POS_IDLE;
				cur_y_q   <= POS_IDLE;
			end
		end else if (cal_load) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			if (!down_q) begin
				// first scan of a press: remember where it began
				down_q    <= 1'b1;
				latched_q <= 1'b1;
				start_x_q <= nx;
				start_y_q <= ny;
			end
		end
	end

	// pen-up requests report no pair match
	logic ok_flag_q;
	always_ff @(posedge clk) begin
		if (req_acc) begin
			ok_flag_q <= 1'b0;
		end else if (cal_load) begin
			ok_flag_q <= ok_q;
		end
	end

	// ---------------- output register ----------------
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res.touching      <= down_q;
			res.pos_x         <= cur_x_q;
			res.pos_y         <= cur_y_q;
			res.first_x       <= start_x_q;
			res.first_y       <= start_y_q;
			res.press_latched <= latched_q;
			res.pair_ok       <= ok_flag_q;
		end
	end

	assign res.valid = out_valid_q;

endmodule
